// ----- sv/assert_macros.svh -----
// Assertion helpers for the engine's top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, switched off while rst_ni is low.
`define KM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check with a generic message.
`define KM_CHECK(lbl, prop) `KM_ASSERT(lbl, prop, "km2d internal check failed")

`endif

// ----- sv/km2d_pkg.sv -----
// ----------------------------------------------------------------------------
// km2d_pkg
// Shared constants, codes and types of the two-dimensional k-means engine.
// ----------------------------------------------------------------------------
package km2d_pkg;

  localparam int COORD_BITS       = 16;
  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_MAX_CLUSTERS = 16;

  localparam int OP_W       = 3;
  localparam int IDX_W      = 10;
  localparam int KIND_W     = 2;
  localparam int LABEL_W    = 4;
  localparam int ROUNDS_W   = 8;
  localparam int NP_REG_W   = 11;
  localparam int NC_REG_W   = 5;
  localparam int MI_REG_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [OP_W-1:0] OP_LOAD_POINT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_CENTRE = 3'd1;
  localparam logic [OP_W-1:0] OP_RUN         = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_LABEL  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_CENTRE = 3'd4;

  localparam logic [KIND_W-1:0] RK_RUN    = 2'd0;
  localparam logic [KIND_W-1:0] RK_LABEL  = 2'd1;
  localparam logic [KIND_W-1:0] RK_CENTRE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [IDX_W-1:0]      index;
    logic [LABEL_W-1:0]    label;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [ROUNDS_W-1:0]   rounds;
    logic                  conv;
  } result_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

// ----- sv/km2d_ram.sv -----
// ----------------------------------------------------------------------------
// km2d_ram
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module km2d_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/km2d_div.sv -----
// ----------------------------------------------------------------------------
// km2d_div
// Restoring divider, one quotient bit per cycle, for the centroid means.
// ----------------------------------------------------------------------------
module km2d_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 11,
  parameter int QUO_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], 1'b0};
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[QUO_W-1:0];

endmodule

// ----- sv/kmeans_2d_lloyd_engine_top.sv -----
// ----------------------------------------------------------------------------
// kmeans_2d_lloyd_engine_top
// Two-dimensional k-means engine (Lloyd's method) over on-chip point storage.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one word each: tuser carries the
// operation (load point, load centroid, run, read label, read centroid) and
// tdata the index and coordinates. Loads give no word out. Reads give one
// word on m_axis, formed in the RDWAIT and RES states after acceptance. A
// run gives one word with the round count and convergence flag once it
// finishes. Each round of a run does a distance search per point (one
// centroid read, one multiply stage and one compare per cluster) and then a
// mean update per cluster with points, which uses two serial dividers.
// Commands are taken one at a time; s_axis_tready is low while a command is
// in progress or while a result waits behind one held by a stalled receiver.
// After reset the label memory is cleared, one entry per cycle; no command
// is accepted during that pass, but configuration writes are. Point and
// centroid memories are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmeans_2d_lloyd_engine_top #(
  parameter int MAX_POINTS   = km2d_pkg::DEF_MAX_POINTS,
  parameter int MAX_CLUSTERS = km2d_pkg::DEF_MAX_CLUSTERS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [km2d_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [km2d_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // item_index[9:0], x_coord[25:10], y_coord[41:26], zero fill
  input  logic [km2d_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // op[2:0]
  input  logic [km2d_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_index[9:0], cluster_label[13:10], centroid_x[29:14],
  // centroid_y[45:30], rounds_done[53:46], converged[54], zero fill
  output logic [km2d_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // result_kind[1:0]
  output logic [km2d_pkg::KIND_W-1:0]         m_axis_tuser
);

  import km2d_pkg::*;

  localparam int PA_W   = $clog2(MAX_POINTS);
  localparam int CA_W   = $clog2(MAX_CLUSTERS);
  localparam int PCNT_W = $clog2(MAX_POINTS + 1);
  localparam int KCNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W  = COORD_BITS + PA_W;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;
  localparam int NPW    = (PCNT_W > NP_REG_W) ? PCNT_W : NP_REG_W;
  localparam int NCW    = (KCNT_W > NC_REG_W) ? KCNT_W : NC_REG_W;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDWAIT = 4'd2;
  localparam logic [3:0] ST_RES    = 4'd3;
  localparam logic [3:0] ST_RSTART = 4'd4;
  localparam logic [3:0] ST_PRD    = 4'd5;
  localparam logic [3:0] ST_CRD    = 4'd6;
  localparam logic [3:0] ST_SQ     = 4'd7;
  localparam logic [3:0] ST_CMP    = 4'd8;
  localparam logic [3:0] ST_WB     = 4'd9;
  localparam logic [3:0] ST_UPD    = 4'd10;
  localparam logic [3:0] ST_DIV    = 4'd11;
  localparam logic [3:0] ST_REND   = 4'd12;

  logic [3:0]            state_q, state_d;
  logic [NP_REG_W-1:0]   cfg_np_q;
  logic [NC_REG_W-1:0]   cfg_nc_q;
  logic [MI_REG_W-1:0]   cfg_mi_q;
  logic [PCNT_W-1:0]     np_q, np_d;
  logic [KCNT_W-1:0]     nc_q, nc_d;
  logic [ROUNDS_W-1:0]   rounds_q, rounds_d;
  logic                  changed_q, changed_d;
  logic [PCNT_W-1:0]     i_q, i_d;
  logic [KCNT_W-1:0]     k_q, k_d;
  logic [PA_W-1:0]       clr_q, clr_d;
  logic                  out_valid_q, out_valid_d;
  logic [DIST_W-1:0]     best_q, best_d;
  logic [CA_W-1:0]       bestk_q, bestk_d;
  logic [SQ_W-1:0]       sqx_q, sqx_d, sqy_q, sqy_d;
  logic                  rd_ok_q, rd_ok_d;
  logic                  rd_lbl_q, rd_lbl_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  result_t               res_q, res_d, out_q, out_d;
  logic [SUM_W-1:0]      sumx_q [MAX_CLUSTERS];
  logic [SUM_W-1:0]      sumy_q [MAX_CLUSTERS];
  logic [PCNT_W-1:0]     cnt_q  [MAX_CLUSTERS];

  logic [IDX_W-1:0]      in_idx;
  logic [COORD_BITS-1:0] in_x, in_y;
  logic                  in_acc, in_pt_ok, in_ce_ok;
  logic [NPW-1:0]        np_ext;
  logic [NCW-1:0]        nc_ext;
  logic [PCNT_W-1:0]     np_sat;
  logic [KCNT_W-1:0]     nc_sat;

  logic                  p_we, p_re, l_we, l_re, c_we, c_re;
  logic [PA_W-1:0]       p_waddr, p_raddr, l_waddr, l_raddr;
  logic [CA_W-1:0]       c_waddr, c_raddr;
  logic [2*COORD_BITS-1:0] p_rdata, c_wdata, c_rdata;
  logic [CA_W-1:0]       l_wdata, l_rdata;
  logic [COORD_BITS-1:0] px, py, cx, cy, dx, dy;
  logic [DIST_W-1:0]     dist_sum;
  logic [CA_W-1:0]       kk;
  logic                  acc_en, clr_sums;
  div_ctrl_t             dctl;
  logic                  dx_done, dy_done;
  logic [COORD_BITS-1:0] qx, qy;

  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_x     = s_axis_tdata[IDX_W +: COORD_BITS];
  assign in_y     = s_axis_tdata[IDX_W+COORD_BITS +: COORD_BITS];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_pt_ok = (32'(in_idx) < MAX_POINTS);
  assign in_ce_ok = (32'(in_idx) < MAX_CLUSTERS);
  assign s_axis_tready = (state_q == ST_IDLE);

  assign np_ext = NPW'(cfg_np_q);
  assign nc_ext = NCW'(cfg_nc_q);
  assign np_sat = (np_ext > NPW'(MAX_POINTS)) ? PCNT_W'(MAX_POINTS) : PCNT_W'(np_ext);
  assign nc_sat = (nc_ext == '0) ? KCNT_W'(1) :
                  (nc_ext > NCW'(MAX_CLUSTERS)) ? KCNT_W'(MAX_CLUSTERS) : KCNT_W'(nc_ext);

  assign px = p_rdata[COORD_BITS-1:0];
  assign py = p_rdata[2*COORD_BITS-1:COORD_BITS];
  assign cx = c_rdata[COORD_BITS-1:0];
  assign cy = c_rdata[2*COORD_BITS-1:COORD_BITS];
  assign dx = (px > cx) ? px - cx : cx - px;
  assign dy = (py > cy) ? py - cy : cy - py;
  assign dist_sum = DIST_W'(sqx_q) + DIST_W'(sqy_q);
  assign kk = k_q[CA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_np_q <= NP_REG_W'(1024);
      cfg_nc_q <= NC_REG_W'(16);
      cfg_mi_q <= MI_REG_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_POINTS:   cfg_np_q <= cfg_data_i[NP_REG_W-1:0];
        REG_NUM_CLUSTERS: cfg_nc_q <= cfg_data_i[NC_REG_W-1:0];
        REG_MAX_ITER:     cfg_mi_q <= cfg_data_i[MI_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    np_d        = np_q;
    nc_d        = nc_q;
    rounds_d    = rounds_q;
    changed_d   = changed_q;
    i_d         = i_q;
    k_d         = k_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    best_d      = best_q;
    bestk_d     = bestk_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    rd_ok_d     = rd_ok_q;
    rd_lbl_d    = rd_lbl_q;
    rd_idx_d    = rd_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    p_we = 1'b0; p_re = 1'b0; l_we = 1'b0; l_re = 1'b0; c_we = 1'b0; c_re = 1'b0;
    p_waddr = PA_W'(in_idx);
    p_raddr = i_q[PA_W-1:0];
    l_waddr = i_q[PA_W-1:0];
    l_raddr = i_q[PA_W-1:0];
    l_wdata = bestk_q;
    c_waddr = CA_W'(in_idx);
    c_raddr = kk;
    c_wdata = {in_y, in_x};
    acc_en   = 1'b0;
    clr_sums = 1'b0;
    dctl.start = 1'b0;
    dctl.done  = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr_q;
        l_wdata = '0;
        clr_d   = clr_q + PA_W'(1);
        if (clr_q == PA_W'(MAX_POINTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          rd_idx_d = in_idx;
          case (s_axis_tuser)
            OP_LOAD_POINT: begin
              p_we = in_pt_ok;
            end
            OP_LOAD_CENTRE: begin
              c_we = in_ce_ok;
            end
            OP_RUN: begin
              np_d     = np_sat;
              nc_d     = nc_sat;
              rounds_d = '0;
              state_d  = ST_RSTART;
            end
            OP_READ_LABEL: begin
              l_re     = in_pt_ok;
              l_raddr  = PA_W'(in_idx);
              rd_ok_d  = in_pt_ok;
              rd_lbl_d = 1'b1;
              state_d  = ST_RDWAIT;
            end
            OP_READ_CENTRE: begin
              c_re     = in_ce_ok;
              c_raddr  = CA_W'(in_idx);
              rd_ok_d  = in_ce_ok;
              rd_lbl_d = 1'b0;
              state_d  = ST_RDWAIT;
            end
            default: ;
          endcase
        end
      end
      ST_RDWAIT: begin
        res_d = '0;
        res_d.index = rd_idx_q;
        if (rd_lbl_q) begin
          res_d.kind = RK_LABEL;
          if (rd_ok_q) begin
            res_d.label = LABEL_W'(l_rdata);
          end
        end else begin
          res_d.kind = RK_CENTRE;
          if (rd_ok_q) begin
            res_d.cx = cx;
            res_d.cy = cy;
          end
        end
        state_d = ST_RES;
      end
      ST_RES: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_RSTART: begin
        if (cfg_mi_q == '0) begin
          res_d   = '0;
          state_d = ST_RES;
        end else begin
          clr_sums  = 1'b1;
          changed_d = 1'b0;
          i_d       = '0;
          k_d       = '0;
          state_d   = (np_q == '0) ? ST_UPD : ST_PRD;
        end
      end
      ST_PRD: begin
        p_re    = 1'b1;
        l_re    = 1'b1;
        k_d     = '0;
        state_d = ST_CRD;
      end
      ST_CRD: begin
        c_re    = 1'b1;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        sqx_d   = SQ_W'(dx) * SQ_W'(dx);
        sqy_d   = SQ_W'(dy) * SQ_W'(dy);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (k_q == '0 || dist_sum < best_q) begin
          best_d  = dist_sum;
          bestk_d = kk;
        end
        if (k_q == nc_q - KCNT_W'(1)) begin
          state_d = ST_WB;
        end else begin
          k_d     = k_q + KCNT_W'(1);
          state_d = ST_CRD;
        end
      end
      ST_WB: begin
        l_we   = 1'b1;
        acc_en = 1'b1;
        if (l_rdata != bestk_q) begin
          changed_d = 1'b1;
        end
        i_d = i_q + PCNT_W'(1);
        if (i_q == np_q - PCNT_W'(1)) begin
          k_d     = '0;
          state_d = ST_UPD;
        end else begin
          state_d = ST_PRD;
        end
      end
      ST_UPD: begin
        if (k_q == nc_q) begin
          state_d = ST_REND;
        end else if (cnt_q[kk] != '0) begin
          dctl.start = 1'b1;
          state_d    = ST_DIV;
        end else begin
          k_d = k_q + KCNT_W'(1);
        end
      end
      ST_DIV: begin
        dctl.done = dy_done;
        if (dy_done) begin
          c_we    = 1'b1;
          c_waddr = kk;
          c_wdata = {qy, qx};
          k_d     = k_q + KCNT_W'(1);
          state_d = ST_UPD;
        end
      end
      ST_REND: begin
        rounds_d = rounds_q + ROUNDS_W'(1);
        if (!changed_q || rounds_d == cfg_mi_q) begin
          res_d        = '0;
          res_d.kind   = RK_RUN;
          res_d.rounds = rounds_d;
          res_d.conv   = !changed_q;
          state_d      = ST_RES;
        end else begin
          state_d = ST_RSTART;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      np_q        <= '0;
      nc_q        <= '0;
      rounds_q    <= '0;
      changed_q   <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
      rd_lbl_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      np_q        <= np_d;
      nc_q        <= nc_d;
      rounds_q    <= rounds_d;
      changed_q   <= changed_d;
      i_q         <= i_d;
      k_q         <= k_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      rd_ok_q     <= rd_ok_d;
      rd_lbl_q    <= rd_lbl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    bestk_q  <= bestk_d;
    sqx_q    <= sqx_d;
    sqy_q    <= sqy_d;
    rd_idx_q <= rd_idx_d;
    res_q    <= res_d;
    out_q    <= out_d;
    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      if (clr_sums) begin
        sumx_q[c] <= '0;
        sumy_q[c] <= '0;
        cnt_q[c]  <= '0;
      end else if (acc_en && bestk_q == CA_W'(c)) begin
        sumx_q[c] <= sumx_q[c] + SUM_W'(px);
        sumy_q[c] <= sumy_q[c] + SUM_W'(py);
        cnt_q[c]  <= cnt_q[c] + PCNT_W'(1);
      end
    end
  end

  km2d_ram #(.DEPTH(MAX_POINTS), .WIDTH(2 * COORD_BITS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i ({in_y, in_x}),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  km2d_ram #(.DEPTH(MAX_POINTS), .WIDTH(CA_W)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  km2d_ram #(.DEPTH(MAX_CLUSTERS), .WIDTH(2 * COORD_BITS)) u_centre_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  km2d_div #(.NUM_W(SUM_W), .DEN_W(PCNT_W), .QUO_W(COORD_BITS)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dctl.start),
    .num_i   (sumx_q[kk]),
    .den_i   (cnt_q[kk]),
    .done_o  (dx_done),
    .quo_o   (qx)
  );

  km2d_div #(.NUM_W(SUM_W), .DEN_W(PCNT_W), .QUO_W(COORD_BITS)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dctl.start),
    .num_i   (sumy_q[kk]),
    .den_i   (cnt_q[kk]),
    .done_o  (dy_done),
    .quo_o   (qy)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {1'b0, out_q.conv, out_q.rounds, out_q.cy, out_q.cx,
                          out_q.label, out_q.index};

  `KM_CHECK(a_no_accept_in_clear, state_q == ST_CLEAR |-> !s_axis_tready)
  `KM_ASSERT(a_cluster_in_range, state_q == ST_CMP |-> k_q < nc_q,
             "cluster index beyond clusters in use")
  `KM_ASSERT(a_div_done_returns, dctl.done |=> state_q == ST_UPD,
             "divider completion not followed by update step")
  `KM_ASSERT(a_round_limit, state_q == ST_REND |-> rounds_q < cfg_mi_q,
             "round count passed the iteration limit")
  `KM_CHECK(a_div_lockstep, dx_done == dy_done)

endmodule

// ----- dv/kmeans_2d_lloyd_engine_top_tb.sv -----
// ----------------------------------------------------------------------------
// kmeans_2d_lloyd_engine_top_tb
// Self-checking bench for the two-dimensional k-means engine.
// ----------------------------------------------------------------------------
// Commands are sent on the slave stream with random gaps while the master
// stream is stalled at random. A behavioural model of the engine predicts
// every output word, and each word is compared field by field with the
// oldest prediction. Directed tests cover the field extremes, ties, ignored
// and out-of-range commands and the register corner values; random phases
// then load clustered point sets and mix runs, reads and loads.
// ----------------------------------------------------------------------------
module kmeans_2d_lloyd_engine_top_tb;
  import km2d_pkg::*;

  localparam int NPTS      = DEF_MAX_POINTS;
  localparam int NCLU      = DEF_MAX_CLUSTERS;
  localparam int IDLE_LIMIT = 2000000;
  localparam int DRAIN     = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;

  kmeans_2d_lloyd_engine_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Model state
  logic [COORD_BITS-1:0] pt_x [NPTS];
  logic [COORD_BITS-1:0] pt_y [NPTS];
  logic [LABEL_W-1:0]    pt_label [NPTS];
  logic [COORD_BITS-1:0] ctr_x [NCLU];
  logic [COORD_BITS-1:0] ctr_y [NCLU];
  bit                    ctr_loaded [NCLU];
  int unsigned           reg_points = 1024;
  int unsigned           reg_clusters = 16;
  int unsigned           reg_iters = 32;

  result_t     expected_words[$];
  int unsigned error_count = 0;
  bit          steady_flow = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit lloyd_round(int unsigned np, int unsigned nc);
    bit          changed;
    int unsigned best;
    logic [33:0] best_d, d;
    logic [33:0] dx, dy;
    longint      sx [NCLU];
    longint      sy [NCLU];
    longint      cnt [NCLU];
    changed = 1'b0;
    for (int i = 0; i < np; i++) begin
      best = 0;
      for (int k = 0; k < nc; k++) begin
        dx = (pt_x[i] > ctr_x[k]) ? pt_x[i] - ctr_x[k] : ctr_x[k] - pt_x[i];
        dy = (pt_y[i] > ctr_y[k]) ? pt_y[i] - ctr_y[k] : ctr_y[k] - pt_y[i];
        d = 34'(dx * dx) + 34'(dy * dy);
        if (k == 0 || d < best_d) begin
          best_d = d;
          best = k;
        end
      end
      if (pt_label[i] != best) changed = 1'b1;
      pt_label[i] = best;
    end
    for (int k = 0; k < NCLU; k++) begin
      sx[k] = 0;
      sy[k] = 0;
      cnt[k] = 0;
    end
    for (int i = 0; i < np; i++) begin
      sx[pt_label[i]] += pt_x[i];
      sy[pt_label[i]] += pt_y[i];
      cnt[pt_label[i]] += 1;
    end
    for (int k = 0; k < nc; k++) begin
      if (cnt[k] != 0) begin
        ctr_x[k] = COORD_BITS'(sx[k] / cnt[k]);
        ctr_y[k] = COORD_BITS'(sy[k] / cnt[k]);
      end
    end
    return changed;
  endfunction

  function automatic void predict_command(logic [OP_W-1:0] op, int unsigned idx,
                                          logic [15:0] x, logic [15:0] y);
    result_t     res;
    int unsigned np, nc, rounds;
    bit          conv;
    res = '0;
    case (op)
      OP_LOAD_POINT: begin
        pt_x[idx] = x;
        pt_y[idx] = y;
      end
      OP_LOAD_CENTRE: begin
        if (idx < NCLU) begin
          ctr_x[idx] = x;
          ctr_y[idx] = y;
          ctr_loaded[idx] = 1'b1;
        end
      end
      OP_RUN: begin
        np = (reg_points > NPTS) ? NPTS : reg_points;
        nc = (reg_clusters == 0) ? 1 : (reg_clusters > NCLU) ? NCLU : reg_clusters;
        rounds = 0;
        conv = 1'b0;
        while (rounds < reg_iters && !conv) begin
          conv = !lloyd_round(np, nc);
          rounds++;
        end
        res.kind = RK_RUN;
        res.rounds = rounds;
        res.conv = conv;
        expected_words.push_back(res);
      end
      OP_READ_LABEL: begin
        res.kind = RK_LABEL;
        res.index = idx;
        res.label = pt_label[idx];
        expected_words.push_back(res);
      end
      OP_READ_CENTRE: begin
        res.kind = RK_CENTRE;
        res.index = idx;
        if (idx < NCLU) begin
          res.cx = ctr_x[idx];
          res.cy = ctr_y[idx];
        end
        expected_words.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(logic [OP_W-1:0] op, int unsigned idx,
                              logic [15:0] x = '0, logic [15:0] y = '0);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, y, x, IDX_W'(idx)};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_command(op, idx, x, y);
  endtask

  // Waits for the engine to fall idle, then writes the registers.
  task automatic write_registers(int unsigned np, int unsigned nc, int unsigned mi);
    s_axis_tvalid <= 1'b0;
    wait (expected_words.size() == 0);
    @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_NUM_POINTS;
    cfg_data_i <= CFG_DATA_W'(np);
    @(posedge clk_i);
    cfg_idx_i <= REG_NUM_CLUSTERS;
    cfg_data_i <= CFG_DATA_W'(nc);
    @(posedge clk_i);
    cfg_idx_i <= REG_MAX_ITER;
    cfg_data_i <= CFG_DATA_W'(mi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_points = np & 11'h7FF;
    reg_clusters = nc & 5'h1F;
    reg_iters = mi & 8'hFF;
  endtask

  task automatic load_point_set(int unsigned np, int unsigned nc);
    logic [15:0] ax [4];
    logic [15:0] ay [4];
    int unsigned a;
    for (int k = 0; k < 4; k++) begin
      ax[k] = $urandom;
      ay[k] = $urandom;
    end
    for (int i = 0; i < np; i++) begin
      a = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0)
        send_command(OP_LOAD_POINT, i, $urandom, $urandom);
      else
        send_command(OP_LOAD_POINT, i, ax[a] ^ ($urandom & 16'h03FF),
                     ay[a] ^ ($urandom & 16'h03FF));
    end
    for (int k = 0; k < nc; k++)
      send_command(OP_LOAD_CENTRE, k, $urandom, $urandom);
  endtask

  task automatic test_directed();
    write_registers(4, 3, 8);
    send_command(OP_LOAD_POINT, 0, 16'h0000, 16'h0000);
    send_command(OP_LOAD_POINT, 1, 16'hFFFF, 16'hFFFF);
    send_command(OP_LOAD_POINT, 2, 16'h0000, 16'hFFFF);
    send_command(OP_LOAD_POINT, 3, 16'h8000, 16'h8000);
    send_command(OP_LOAD_POINT, 1023, 16'hFFFF, 16'h0000);
    send_command(OP_LOAD_CENTRE, 0, 16'h4000, 16'h8000);
    send_command(OP_LOAD_CENTRE, 1, 16'hC000, 16'h8000);
    send_command(OP_LOAD_CENTRE, 2, 16'hFFFF, 16'hFFFF);
    send_command(OP_LOAD_CENTRE, 1023, 16'h1234, 16'h5678);
    send_command(OP_LOAD_CENTRE, 15, 16'hFFFF, 16'h0000);
    send_command(3'd5, 7, 16'hAAAA, 16'h5555);
    send_command(3'd6, 0);
    send_command(3'd7, 1023, 16'hFFFF, 16'hFFFF);
    send_command(OP_READ_LABEL, 1023);
    send_command(OP_READ_CENTRE, 15);
    send_command(OP_READ_CENTRE, 700);
    send_command(OP_RUN, 0);
    for (int i = 0; i < 4; i++) send_command(OP_READ_LABEL, i);
    for (int k = 0; k < 3; k++) send_command(OP_READ_CENTRE, k);
  endtask

  task automatic test_register_extremes();
    write_registers(0, 0, 5);
    send_command(OP_RUN, 0);
    write_registers(4, 2, 0);
    send_command(OP_RUN, 0);
    send_command(OP_READ_CENTRE, 0);
    write_registers(4, 0, 255);
    send_command(OP_RUN, 0);
    send_command(OP_READ_LABEL, 2);
    for (int k = 0; k < NCLU; k++)
      if (!ctr_loaded[k]) send_command(OP_LOAD_CENTRE, k, $urandom, $urandom);
    write_registers(4, 21, 1);
    send_command(OP_RUN, 0);
    send_command(OP_READ_LABEL, 1023);
    send_command(OP_READ_LABEL, 3);
    send_command(OP_READ_CENTRE, 15);
    write_registers(4, 16, 2);
    send_command(OP_RUN, 0);
    send_command(OP_READ_LABEL, 2);
  endtask

  function automatic logic [OP_W-1:0] OP_OPS_JUNK();
    return OP_W'($urandom_range(5, 7));
  endfunction

  task automatic test_random_phases();
    int unsigned np, nc, mi, r, idx;
    for (int p = 0; p < 12; p++) begin
      steady_flow = (p % 4 == 3);
      np = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
      nc = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
      r = $urandom_range(0, 9);
      mi = (r == 0) ? 255 : (r == 1) ? 1 : $urandom_range(2, 20);
      write_registers(np, nc, mi);
      load_point_set(np, nc);
      for (int n = 0; n < 22; n++) begin
        r = $urandom_range(0, 99);
        idx = $urandom_range(0, 1023);
        if (r < 20) send_command(OP_RUN, idx);
        else if (r < 42) send_command(OP_READ_LABEL, idx);
        else if (r < 62) begin
          if (idx < NCLU && !ctr_loaded[idx]) idx += NCLU;
          if ($urandom_range(0, 1)) idx = $urandom_range(0, NCLU - 1) % (nc + 0);
          send_command(OP_READ_CENTRE, idx);
        end else if (r < 78) send_command(OP_LOAD_POINT, idx, $urandom, $urandom);
        else if (r < 94)
          send_command(OP_LOAD_CENTRE, $urandom_range(0, 1) ? idx % NCLU : idx,
                       $urandom, $urandom);
        else send_command(OP_OPS_JUNK(), idx, $urandom, $urandom);
      end
    end
    steady_flow = 1'b0;
  endtask

  task automatic compare_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word, expected none actual %0h", $time,
                 m_axis_tdata);
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        compare_field("result_kind", exp_w.kind, m_axis_tuser);
        compare_field("result_index", exp_w.index, m_axis_tdata[9:0]);
        compare_field("cluster_label", exp_w.label, m_axis_tdata[13:10]);
        compare_field("centroid_x", exp_w.cx, m_axis_tdata[29:14]);
        compare_field("centroid_y", exp_w.cy, m_axis_tdata[45:30]);
        compare_field("rounds_done", exp_w.rounds, m_axis_tdata[53:46]);
        compare_field("converged", exp_w.conv, m_axis_tdata[54]);
      end
    end
  end

  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 99) < 30)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else if (idle_cycles == IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    for (int i = 0; i < NPTS; i++) begin
      pt_x[i] = '0;
      pt_y[i] = '0;
      pt_label[i] = '0;
    end
    for (int k = 0; k < NCLU; k++) begin
      ctr_x[k] = '0;
      ctr_y[k] = '0;
      ctr_loaded[k] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_phases();
    s_axis_tvalid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
